// ===== sv/section_collection_tracker_top_assert.svh =====
// assertion macros for the section collection tracker
`ifndef SECTION_COLLECTION_TRACKER_TOP_ASSERT_SVH
`define SECTION_COLLECTION_TRACKER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define SCT_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("sct check failed");

// next-cycle implication, sampled on clock, off during reset
`define SCT_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("sct check failed");

`endif

// ===== sv/sct_pkg.sv =====
// shared types and constants of the section collection tracker
package sct_pkg;

   localparam int DEF_SLOTS        = 16;
   localparam int DEF_MAX_SECTIONS = 32;

   localparam int ID_W     = 16;
   localparam int COUNT_W  = 5;
   localparam int SEC_NUM_W = 8;
   localparam int STATUS_W = 3;
   localparam int SLOT_OUT_W = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [ID_W-1:0]    RESET_FIRST_ID = 16'h0001;
   localparam logic [COUNT_W-1:0] RESET_COUNT    = 5'h0B;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ID = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT    = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STAT_UNKNOWN = 3'd0,
      STAT_NEW     = 3'd1,
      STAT_REJECT  = 3'd2,
      STAT_DONE    = 3'd3,
      STAT_RANGE   = 3'd4,
      STAT_CLEARED = 3'd5
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // decision of one item, handed from the update logic to the top level
   typedef struct packed {
      logic       accept;
      status_type status;
      logic       write_entry;
      logic       set_complete;
      logic       set_done;
      logic       clear_all;
   } sct_ctrl_type;

endpackage

// ===== sv/section_collection_tracker_top.sv =====
// section collection tracker top level: slot memory, control and output register
//
//   channel   dir   handshake                 beat contents
//   req       in    req_valid / req_stall     mode, bouquet id, section, last section
//   rsp       out   rsp_valid / rsp_stall     accept, status, slot, all done
//   csr       in    csr_wr_en                 register index and write data
//
// each request is handled in order: the accept edge reads the slot memory, and
// the execute state writes the updated entry back and loads the response register
// the slot memory has a single read port; a new request is taken in the cycle
// after write-back, so the same slot never needs forwarding
// reset and the clear request empty all slots at once through per-slot valid bits
// a stalled response holds the block in its execute state until the beat leaves
module section_collection_tracker_top #(
   parameter int SLOTS        = sct_pkg::DEF_SLOTS,
   parameter int MAX_SECTIONS = sct_pkg::DEF_MAX_SECTIONS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_mode,
   input  logic [sct_pkg::ID_W-1:0]        req_bouquet_id,
   input  logic [sct_pkg::SEC_NUM_W-1:0]   req_section_number,
   input  logic [sct_pkg::SEC_NUM_W-1:0]   req_last_section_number,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_accept,
   output logic [sct_pkg::STATUS_W-1:0]    rsp_status,
   output logic [sct_pkg::SLOT_OUT_W-1:0]  rsp_slot,
   output logic                            rsp_all_done,
   // register write port
   input  logic                            csr_wr_en,
   input  logic [sct_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sct_pkg::ID_W-1:0]        csr_wr_data
);
   import sct_pkg::*;

   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ENTRY_W = 2 * MAX_SECTIONS;

   // configuration registers
   logic [ID_W-1:0]    first_id_ff;
   logic [COUNT_W-1:0] count_ff;

   // control
   state_type state_ff, state_in;
   logic      req_fire;
   logic      exec_go;

   // captured request
   logic                  mode_ff;
   logic                  known_ff;
   logic                  sec_ok_ff;
   logic [SLOT_W-1:0]     addr_ff;
   logic [SLOT_OUT_W-1:0] slot_ff;
   logic [SEC_NUM_W-1:0]  sec_ff;
   logic [SEC_NUM_W-1:0]  last_ff;

   // slot memory: {expected, received} per slot
   logic [ENTRY_W-1:0] slot_mem [SLOTS];
   logic [ENTRY_W-1:0] rdata_ff;
   logic [ENTRY_W-1:0] entry;
   logic [SLOTS-1:0]   valid_ff;
   logic [SLOTS-1:0]   complete_ff;
   logic               done_ff;

   // lookup
   logic [ID_W-1:0]  offset;
   logic             known;
   logic [SLOTS-1:0] track_mask;
   logic             all_complete;

   // update results
   logic [MAX_SECTIONS-1:0] exp_d;
   logic [MAX_SECTIONS-1:0] rcv_d;
   sct_ctrl_type            ctrl;

   // response register
   logic                  rsp_valid_ff;
   logic                  rsp_accept_ff;
   status_type            rsp_status_ff;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff;
   logic                  rsp_all_done_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_id_ff <= RESET_FIRST_ID;
         count_ff    <= RESET_COUNT;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FIRST_ID: first_id_ff <= csr_wr_data;
            CSR_COUNT:    count_ff    <= csr_wr_data[COUNT_W-1:0];
            default:      ;
         endcase
      end
   end

   // id to slot mapping, wrapping modulo the id space
   assign offset = req_bouquet_id - first_id_ff;
   assign known  = (offset < ID_W'(count_ff)) && (32'(offset) < 32'(SLOTS));

   // only slots below the configured count must be complete
   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         track_mask[i] = (32'(i) < 32'(count_ff));
      end
   end
   assign all_complete = &(complete_ff | ~track_mask);

   // state machine: next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_EXEC;
         ST_EXEC: if (exec_go)   state_in = ST_IDLE;
         default:                state_in = ST_IDLE;
      endcase
   end

   // state machine: outputs
   always_comb begin
      req_stall = 1'b1;
      exec_go   = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_EXEC: exec_go   = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign req_fire = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // capture the request beat, a clear beat reports slot zero
   always_ff @(posedge clock) begin
      if (req_fire) begin
         mode_ff   <= req_mode;
         known_ff  <= known;
         sec_ok_ff <= (req_section_number < SEC_NUM_W'(MAX_SECTIONS));
         addr_ff   <= offset[SLOT_W-1:0];
         slot_ff   <= (known && !req_mode) ? offset[SLOT_OUT_W-1:0] : '0;
         sec_ff    <= req_section_number;
         last_ff   <= req_last_section_number;
      end
   end

   // slot memory: read on accept, write back on execute
   always_ff @(posedge clock) begin
      if (req_fire) rdata_ff <= slot_mem[offset[SLOT_W-1:0]];
      if (exec_go && ctrl.write_entry) slot_mem[addr_ff] <= {exp_d, rcv_d};
   end

   // an entry never written since the last clear reads as empty
   assign entry = (known_ff && valid_ff[addr_ff]) ? rdata_ff : '0;

   sct_update #(
      .MAX_SECTIONS(MAX_SECTIONS)
   ) u_update (
      .mode               (mode_ff),
      .known              (known_ff),
      .sec_ok             (sec_ok_ff),
      .section_number     (sec_ff),
      .last_section_number(last_ff),
      .exp_q              (entry[ENTRY_W-1:MAX_SECTIONS]),
      .rcv_q              (entry[MAX_SECTIONS-1:0]),
      .complete_q         (known_ff && complete_ff[addr_ff]),
      .all_complete       (all_complete),
      .exp_d              (exp_d),
      .rcv_d              (rcv_d),
      .ctrl               (ctrl)
   );

   // per-slot flags and the sticky done flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         complete_ff <= '0;
         done_ff     <= 1'b0;
      end else if (exec_go) begin
         if (ctrl.clear_all) begin
            valid_ff    <= '0;
            complete_ff <= '0;
            done_ff     <= 1'b0;
         end else begin
            if (ctrl.write_entry)  valid_ff[addr_ff]    <= 1'b1;
            if (ctrl.set_complete) complete_ff[addr_ff] <= 1'b1;
            if (ctrl.set_done)     done_ff              <= 1'b1;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_accept_ff   <= ctrl.accept;
         rsp_status_ff   <= ctrl.status;
         rsp_slot_ff     <= slot_ff;
         rsp_all_done_ff <= !ctrl.clear_all && (done_ff || ctrl.set_done);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accept   = rsp_accept_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_all_done = rsp_all_done_ff;

   `include "section_collection_tracker_top_assert.svh"

   // a confirmed completion always carries accept and the done flag
   `SCT_ASSERT_NOW(a_done_beat, rsp_valid_ff && (rsp_status_ff == STAT_DONE), rsp_accept_ff && rsp_all_done_ff)
   // an accepted request is always followed by the execute cycle
   `SCT_ASSERT_NEXT(a_fire_exec, req_fire, state_ff == ST_EXEC)
   // a clear empties every slot and drops the done flag
   `SCT_ASSERT_NEXT(a_clear_empty, exec_go && mode_ff, (valid_ff == '0) && (complete_ff == '0) && !done_ff)
   // the done flag rises only through a write-back
   `SCT_ASSERT_NOW(a_done_source, $rose(done_ff), $past(exec_go))

endmodule

// ===== sv/sct_update.sv =====
// read-modify-write decision for one slot entry
module sct_update #(
   parameter int MAX_SECTIONS = sct_pkg::DEF_MAX_SECTIONS
) (
   input  logic                            mode,
   input  logic                            known,
   input  logic                            sec_ok,
   input  logic [sct_pkg::SEC_NUM_W-1:0]   section_number,
   input  logic [sct_pkg::SEC_NUM_W-1:0]   last_section_number,
   input  logic [MAX_SECTIONS-1:0]         exp_q,
   input  logic [MAX_SECTIONS-1:0]         rcv_q,
   input  logic                            complete_q,
   input  logic                            all_complete,
   output logic [MAX_SECTIONS-1:0]         exp_d,
   output logic [MAX_SECTIONS-1:0]         rcv_d,
   output sct_pkg::sct_ctrl_type           ctrl
);
   import sct_pkg::*;

   localparam int SEC_W = $clog2(MAX_SECTIONS);

   logic [MAX_SECTIONS-1:0] first_mask;
   logic [MAX_SECTIONS-1:0] sec_bit;
   logic                    hit;

   // bits 0..last, saturating to all bits
   always_comb begin
      for (int i = 0; i < MAX_SECTIONS; i++) begin
         first_mask[i] = (SEC_NUM_W'(i) <= last_section_number);
      end
   end

   always_comb begin
      sec_bit = '0;
      sec_bit[section_number[SEC_W-1:0]] = 1'b1;
   end

   assign exp_d = (exp_q == '0) ? first_mask : exp_q;
   assign hit   = |(rcv_q & sec_bit);

   always_comb begin
      rcv_d = rcv_q;
      ctrl  = '{accept: 1'b0, status: STAT_UNKNOWN, write_entry: 1'b0,
                set_complete: 1'b0, set_done: 1'b0, clear_all: 1'b0};
      if (mode) begin
         ctrl.status    = STAT_CLEARED;
         ctrl.clear_all = 1'b1;
      end else if (!known) begin
         ctrl.status = STAT_UNKNOWN;
      end else if (!sec_ok) begin
         ctrl.status = STAT_RANGE;
      end else begin
         ctrl.write_entry = 1'b1;
         if (!complete_q) begin
            if (hit) begin
               ctrl.set_complete = (exp_d == rcv_q);
               ctrl.status       = STAT_REJECT;
            end else begin
               rcv_d       = rcv_q | sec_bit;
               ctrl.accept = 1'b1;
               ctrl.status = STAT_NEW;
            end
         end else if (hit && all_complete) begin
            ctrl.set_done = 1'b1;
            ctrl.accept   = 1'b1;
            ctrl.status   = STAT_DONE;
         end else begin
            ctrl.status = STAT_REJECT;
         end
      end
   end

endmodule
